FILE: rtl/datetime_to_rtc_bcd_registers_defines.svh
//------------------------------------------------------------------------------
// Assertion macros for the RTC BCD register encoder
// Immediate-consequence and next-cycle property wrappers used by the checker.
//------------------------------------------------------------------------------
`ifndef DATETIME_TO_RTC_BCD_REGISTERS_DEFINES_SVH
`define DATETIME_TO_RTC_BCD_REGISTERS_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define DTRTC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define DTRTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle check that is evaluated during reset as well.
`define DTRTC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/dtrtc_pkg.sv
//------------------------------------------------------------------------------
// RTC BCD encoder package
// Shared word layouts and widths for the date/time to RTC register encoder.
//------------------------------------------------------------------------------
`default_nettype none

package dtrtc_pkg;

   // Packed stream word widths, rounded up to whole bytes.
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 56;

   // One binary date and time word.
   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } datetime_type;

   // One set of RTC register bytes.
   typedef struct packed {
      logic       valid_res;
      logic [7:0] second_bcd;
      logic [7:0] minute_bcd;
      logic [7:0] hour_bcd;
      logic [7:0] day_bcd;
      logic [2:0] weekday_value;
      logic [7:0] month_byte;
      logic [7:0] year_bcd;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/datetime_to_rtc_bcd_registers.sv
// Path: an accepted word passes through the input register and then the
// result register before its result shows on the output.
// Throughput: one word per cycle; the encoder is a single pass of logic
// between the two registers, so ready stays high unless the output stalls.
// Reset: synchronous, active high; clears both pipeline valid flags.
//------------------------------------------------------------------------------
// Date/time to RTC BCD register encoder
// Stream wrapper with an input register and a result register around the
// BCD encoder and weekday calculator.
//------------------------------------------------------------------------------
`default_nettype none

module datetime_to_rtc_bcd_registers (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
   // second[37:32], zero fill [39:38]
   input  wire logic [39:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // second_bcd[7:0], minute_bcd[15:8], hour_bcd[23:16], day_bcd[31:24],
   // weekday_value[34:32], month_byte[42:35], year_bcd[50:43], zero fill [55:51]
   output logic      [55:0] rsp_tdata,
   // valid_res[0]
   output logic      [0:0]  rsp_tuser
);

   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   dtrtc_pkg::datetime_type s1_data_ff;
   dtrtc_pkg::datetime_type s1_data_in;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   dtrtc_pkg::result_type   out_res_ff;
   dtrtc_pkg::result_type   out_res_in;
   dtrtc_pkg::result_type   enc_res;
   logic                    out_ready;
   logic                    s1_ready;

   // Pipeline flow control: each stage advances when the next can take it.
   always_comb begin
      out_ready  = !out_valid_ff || rsp_tready;
      s1_ready   = !s1_valid_ff || out_ready;
      req_tready = s1_ready;
   end

   // Input register next values.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (s1_ready) begin
         s1_valid_in = req_tvalid;
      end
      if (s1_ready && req_tvalid) begin
         s1_data_in.year   = req_tdata[11:0];
         s1_data_in.month  = req_tdata[15:12];
         s1_data_in.day    = req_tdata[20:16];
         s1_data_in.hour   = req_tdata[25:21];
         s1_data_in.minute = req_tdata[31:26];
         s1_data_in.second = req_tdata[37:32];
      end
   end

   dtrtc_encode u_encode (
      .dt  (s1_data_ff),
      .res (enc_res)
   );

   // Result register next values.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (out_ready) begin
         out_valid_in = s1_valid_ff;
      end
      if (out_ready && s1_valid_ff) begin
         out_res_in = enc_res;
      end
   end

   // Valid flags take reset; payload registers do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_data_ff <= s1_data_in;
      out_res_ff <= out_res_in;
   end

   // Pack the result word.
   always_comb begin
      rsp_tvalid          = out_valid_ff;
      rsp_tuser[0]        = out_res_ff.valid_res;
      rsp_tdata           = '0;
      rsp_tdata[7:0]      = out_res_ff.second_bcd;
      rsp_tdata[15:8]     = out_res_ff.minute_bcd;
      rsp_tdata[23:16]    = out_res_ff.hour_bcd;
      rsp_tdata[31:24]    = out_res_ff.day_bcd;
      rsp_tdata[34:32]    = out_res_ff.weekday_value;
      rsp_tdata[42:35]    = out_res_ff.month_byte;
      rsp_tdata[50:43]    = out_res_ff.year_bcd;
   end

endmodule

`default_nettype wire

FILE: rtl/dtrtc_weekday.sv
//------------------------------------------------------------------------------
// Weekday calculator
// Day of week, 1 for Monday to 7 for Sunday, from a century offset date.
//------------------------------------------------------------------------------
`default_nettype none

module dtrtc_weekday (
   input  wire logic [6:0] offset,    // year offset within its century, 0..99
   input  wire logic       c2000,     // year lies in 2000..2098
   input  wire logic [3:0] month,
   input  wire logic [4:0] day,
   output logic      [2:0] weekday
);

   // Month contribution 2m + 3(m+1)/5 reduced mod 7, with January and
   // February counted as months 13 and 14 of the previous year.
   function automatic logic [2:0] month_term(input logic [3:0] m);
      logic [2:0] t;
      case (m)
         4'd1:    t = 3'd6;
         4'd2:    t = 3'd2;
         4'd3:    t = 3'd1;
         4'd4:    t = 3'd4;
         4'd5:    t = 3'd6;
         4'd6:    t = 3'd2;
         4'd7:    t = 3'd4;
         4'd8:    t = 3'd0;
         4'd9:    t = 3'd3;
         4'd10:   t = 3'd5;
         4'd11:   t = 3'd1;
         4'd12:   t = 3'd3;
         default: t = 3'd0;
      endcase
      return t;
   endfunction

   logic       jan_feb;
   logic       wrap;
   logic [6:0] off_w;
   logic       c_w;
   logic [7:0] sum;
   logic [4:0] fold1;
   logic [3:0] fold2;
   logic [3:0] rem7;

   // Step back one year for January and February. January or February 2000
   // falls into 1999, the last year of the previous century.
   always_comb begin
      jan_feb = (month == 4'd1) || (month == 4'd2);
      wrap    = jan_feb && c2000 && (offset == 7'd0);
      if (wrap) begin
         off_w = 7'd99;
         c_w   = 1'b0;
      end else if (jan_feb) begin
         off_w = offset - 7'd1;
         c_w   = c2000;
      end else begin
         off_w = offset;
         c_w   = c2000;
      end
   end

   // The century parts y/4 - y/100 + y/400 and the base year reduce mod 7 to
   // zero for the 2000s and to one for the 1900s.
   always_comb begin
      sum = {3'd0, day} + {5'd0, month_term(month)} + {1'b0, off_w}
          + {3'd0, off_w[6:2]} + {7'd0, ~c_w};
   end

   // Modulo 7 by folding octal digits, since 8 is 1 mod 7.
   always_comb begin
      fold1 = {2'd0, sum[2:0]} + {2'd0, sum[5:3]} + {3'd0, sum[7:6]};
      fold2 = {1'b0, fold1[2:0]} + {2'd0, fold1[4:3]};
      rem7  = (fold2 >= 4'd7) ? (fold2 - 4'd7) : fold2;
      weekday = rem7[2:0] + 3'd1;
   end

endmodule

`default_nettype wire

FILE: rtl/dtrtc_encode.sv
//------------------------------------------------------------------------------
// RTC register encoder
// Range checks one date and time and builds the seven BCD register bytes.
//------------------------------------------------------------------------------
`default_nettype none

module dtrtc_encode (
   input  wire dtrtc_pkg::datetime_type dt,
   output dtrtc_pkg::result_type        res
);

   // Two BCD digits of a value up to 99; tens by the reciprocal 205/2048.
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [7:0]  tens_x10;
      logic [7:0]  ones;
      prod     = {8'd0, v} * 15'd205;
      tens     = prod[14:11];
      tens_x10 = {1'b0, tens, 3'd0} + {3'd0, tens, 1'b0};
      ones     = {1'b0, v} - tens_x10;
      return {tens, ones[3:0]};
   endfunction

   logic        in1900;
   logic        in2000;
   logic [11:0] year_diff;
   logic [6:0]  offset;
   logic        ok;
   logic [2:0]  weekday;
   logic [7:0]  month_bcd;

   // Century window and offset within it.
   always_comb begin
      in2000    = (dt.year >= 12'd2000) && (dt.year <= 12'd2098);
      in1900    = (dt.year >= 12'd1901) && (dt.year <= 12'd1999);
      year_diff = in2000 ? (dt.year - 12'd2000) : (dt.year - 12'd1900);
      offset    = year_diff[6:0];
   end

   // Range checks on every field; the day is not checked against the month.
   always_comb begin
      ok = (in1900 || in2000)
         && (dt.month >= 4'd1) && (dt.month <= 4'd12)
         && (dt.day != 5'd0)
         && (dt.hour <= 5'd23)
         && (dt.minute <= 6'd59)
         && (dt.second <= 6'd59);
   end

   dtrtc_weekday u_weekday (
      .offset  (offset),
      .c2000   (in2000),
      .month   (dt.month),
      .day     (dt.day),
      .weekday (weekday)
   );

   // Result bytes, all zero when any check fails.
   always_comb begin
      month_bcd = to_bcd({3'd0, dt.month});
      res = '0;
      if (ok) begin
         res.valid_res     = 1'b1;
         res.second_bcd    = to_bcd({1'b0, dt.second});
         res.minute_bcd    = to_bcd({1'b0, dt.minute});
         res.hour_bcd      = to_bcd({2'd0, dt.hour});
         res.day_bcd       = to_bcd({2'd0, dt.day});
         res.weekday_value = weekday;
         res.month_byte    = {in1900, month_bcd[6:0]};
         res.year_bcd      = to_bcd(offset);
      end
   end

endmodule

`default_nettype wire

FILE: rtl/dtrtc_checker.sv
//------------------------------------------------------------------------------
// RTC BCD encoder port checker
// Watches the top-level ports and flags results that break the encoding.
//------------------------------------------------------------------------------
`default_nettype none

`include "datetime_to_rtc_bcd_registers_defines.svh"

module dtrtc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   // A stalled result word holds its value.
   `DTRTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result word changed while stalled")

   // A rejected date carries all-zero register bytes.
   `DTRTC_ASSERT_NOW(a_invalid_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == 56'd0, "invalid result with nonzero bytes")

   // An accepted date has a weekday and decimal digits in the low bytes.
   `DTRTC_ASSERT_NOW(a_valid_digits, clock, reset, rsp_tvalid && rsp_tuser[0], (rsp_tdata[34:32] != 3'd0) && (rsp_tdata[3:0] <= 4'd9) && (rsp_tdata[7:4] <= 4'd5) && (rsp_tdata[11:8] <= 4'd9), "bad weekday or BCD digit")

   // Nothing is presented right after reset.
   `DTRTC_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "result valid after reset")

endmodule

bind datetime_to_rtc_bcd_registers dtrtc_checker u_checker (.*);

`default_nettype wire

FILE: tb/datetime_to_rtc_bcd_registers_tb.sv
//------------------------------------------------------------------------------
// Testbench for the date/time to RTC BCD register encoder
// Drives binary date/time words with random gaps, predicts the RTC register
// bytes and the weekday for each accepted word, and compares every result
// word field by field while the result side stalls at random.
//------------------------------------------------------------------------------
module datetime_to_rtc_bcd_registers_tb;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [dtrtc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [dtrtc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]                       rsp_tuser;

   // Register sets still owed by the block, oldest first.
   dtrtc_pkg::result_type rtc_expected_q[$];
   int                    error_count = 0;
   // When set, both sides run without gaps or stalls.
   bit                    no_idle = 1'b0;

   datetime_to_rtc_bcd_registers DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #2000000;
      $display("datetime_to_rtc_bcd_registers regression: fail");
      $finish;
   end

   function automatic logic [7:0] to_bcd(int unsigned v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   // Expected RTC register set for one date/time word.
   function automatic dtrtc_pkg::result_type encode_rtc(dtrtc_pkg::datetime_type dt);
      dtrtc_pkg::result_type r;
      int unsigned           offset;
      int unsigned           y;
      int unsigned           m;
      int unsigned           wsum;
      logic                  ok;
      r = '0;
      ok = 1'b1;
      offset = 0;
      if (dt.year >= 2000 && dt.year <= 2098) begin
         offset = dt.year - 2000;
      end else if (dt.year >= 1901 && dt.year <= 1999) begin
         offset = dt.year - 1900;
      end else begin
         ok = 1'b0;
      end
      if (dt.month < 1 || dt.month > 12) ok = 1'b0;
      if (dt.day < 1) ok = 1'b0;
      if (dt.hour > 23) ok = 1'b0;
      if (dt.minute > 59) ok = 1'b0;
      if (dt.second > 59) ok = 1'b0;
      if (!ok) return r;

      r.valid_res  = 1'b1;
      r.second_bcd = to_bcd(dt.second);
      r.minute_bcd = to_bcd(dt.minute);
      r.hour_bcd   = to_bcd(dt.hour);
      r.day_bcd    = to_bcd(dt.day);
      // Weekday congruence; January and February count as months 13 and 14
      // of the year before.
      y = dt.year;
      m = dt.month;
      if (m <= 2) begin
         m = m + 12;
         y = y - 1;
      end
      wsum = dt.day + 2 * m + (3 * (m + 1)) / 5 + y + y / 4 - y / 100 + y / 400;
      r.weekday_value = 3'((wsum % 7) + 1);
      r.month_byte = to_bcd(dt.month) | ((dt.year < 2000) ? 8'h80 : 8'h00);
      r.year_bcd = to_bcd(offset);
      return r;
   endfunction

   // Sends one date/time word after a random gap and records its expected
   // result once the word is accepted. Called at a rising edge.
   task automatic send_datetime(dtrtc_pkg::datetime_type dt);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, dt.second, dt.minute, dt.hour, dt.day, dt.month, dt.year};
      do @(posedge clock); while (req_tready !== 1'b1);
      rtc_expected_q.push_back(encode_rtc(dt));
   endtask

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   // Result side: random stalls per word, and a field-by-field check of every
   // accepted result word against the oldest expectation.
   initial begin : result_checker
      int unsigned           stall;
      dtrtc_pkg::result_type want;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         if (rtc_expected_q.size() == 0) begin
            $error("result word with no date/time word pending: tdata %0h tuser %0h",
                   rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = rtc_expected_q.pop_front();
            check_field("valid_res", 8'(want.valid_res), 8'(rsp_tuser[0]));
            check_field("second_bcd", want.second_bcd, rsp_tdata[7:0]);
            check_field("minute_bcd", want.minute_bcd, rsp_tdata[15:8]);
            check_field("hour_bcd", want.hour_bcd, rsp_tdata[23:16]);
            check_field("day_bcd", want.day_bcd, rsp_tdata[31:24]);
            check_field("weekday_value", 8'(want.weekday_value), 8'(rsp_tdata[34:32]));
            check_field("month_byte", want.month_byte, rsp_tdata[42:35]);
            check_field("year_bcd", want.year_bcd, rsp_tdata[50:43]);
         end
      end
   end

   function automatic dtrtc_pkg::datetime_type make_dt(int unsigned year,
                                                       int unsigned month,
                                                       int unsigned day,
                                                       int unsigned hour,
                                                       int unsigned minute,
                                                       int unsigned second);
      dtrtc_pkg::datetime_type dt;
      dt.year   = 12'(year);
      dt.month  = 4'(month);
      dt.day    = 5'(day);
      dt.hour   = 5'(hour);
      dt.minute = 6'(minute);
      dt.second = 6'(second);
      return dt;
   endfunction

   // Year edges of both centuries, the years just outside them, and the
   // extremes of the 12-bit field. January and February dates exercise the
   // weekday month shift.
   task automatic test_year_range();
      send_datetime(make_dt(1900, 6, 15, 12, 30, 30));
      send_datetime(make_dt(1901, 1, 1, 0, 0, 0));
      send_datetime(make_dt(1999, 12, 31, 23, 59, 59));
      send_datetime(make_dt(2000, 1, 1, 0, 0, 0));
      send_datetime(make_dt(2098, 2, 28, 7, 8, 9));
      send_datetime(make_dt(2099, 1, 1, 0, 0, 0));
      send_datetime(make_dt(0, 0, 0, 0, 0, 0));
      send_datetime(make_dt(4095, 15, 31, 31, 63, 63));
   endtask

   // One field out of range at a time, plus the largest valid values.
   task automatic test_field_limits();
      send_datetime(make_dt(2024, 12, 31, 23, 59, 59));
      send_datetime(make_dt(2024, 0, 10, 10, 10, 10));
      send_datetime(make_dt(2024, 13, 10, 10, 10, 10));
      send_datetime(make_dt(2024, 15, 10, 10, 10, 10));
      send_datetime(make_dt(2024, 5, 0, 10, 10, 10));
      send_datetime(make_dt(2024, 5, 10, 24, 10, 10));
      send_datetime(make_dt(2024, 5, 10, 31, 10, 10));
      send_datetime(make_dt(2024, 5, 10, 10, 60, 10));
      send_datetime(make_dt(2024, 5, 10, 10, 63, 10));
      send_datetime(make_dt(2024, 5, 10, 10, 10, 60));
      send_datetime(make_dt(2024, 5, 10, 10, 10, 63));
   endtask

   // Day 31 in a 30-day month and days around a leap day.
   task automatic test_weekday_cases();
      send_datetime(make_dt(2023, 4, 31, 1, 2, 3));
      send_datetime(make_dt(2000, 2, 29, 4, 5, 6));
      send_datetime(make_dt(2000, 3, 1, 7, 8, 9));
   endtask

   // Mostly valid dates with random content, the rest with one field broken,
   // a year on a century edge, or every field random.
   task automatic test_random_dates();
      dtrtc_pkg::datetime_type dt;
      int unsigned             pick;
      int unsigned             edge_years[6] = '{1900, 1901, 1999, 2000, 2098, 2099};
      for (int n = 0; n < 1200; n++) begin
         if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 9);
         dt = make_dt($urandom_range(0, 1) ? $urandom_range(1901, 1999)
                                           : $urandom_range(2000, 2098),
                      $urandom_range(1, 12), $urandom_range(1, 31),
                      $urandom_range(0, 23), $urandom_range(0, 59),
                      $urandom_range(0, 59));
         if (pick == 6) begin
            dt.year = 12'(edge_years[$urandom_range(0, 5)]);
         end else if (pick == 7) begin
            case ($urandom_range(0, 5))
               0: dt.year = 12'($urandom_range(0, 1) ? $urandom_range(0, 1900)
                                                     : $urandom_range(2099, 4095));
               1: dt.month = 4'($urandom_range(0, 1) ? 0 : $urandom_range(13, 15));
               2: dt.day = 5'd0;
               3: dt.hour = 5'($urandom_range(24, 31));
               4: dt.minute = 6'($urandom_range(60, 63));
               default: dt.second = 6'($urandom_range(60, 63));
            endcase
         end else if (pick >= 8) begin
            dt = make_dt($urandom_range(0, 4095), $urandom_range(0, 15),
                         $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 63), $urandom_range(0, 63));
         end
         send_datetime(dt);
      end
      no_idle = 1'b0;
   endtask

   // Sequence: reset, directed tests, random dates, drain, verdict.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      test_year_range();
      test_field_limits();
      test_weekday_cases();
      test_random_dates();
      req_tvalid <= 1'b0;
      while (rtc_expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("datetime_to_rtc_bcd_registers regression: pass");
      end else begin
         $display("datetime_to_rtc_bcd_registers regression: fail");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/dtrtc_pkg.sv
rtl/dtrtc_weekday.sv
rtl/dtrtc_encode.sv
rtl/datetime_to_rtc_bcd_registers.sv
rtl/dtrtc_checker.sv
tb/datetime_to_rtc_bcd_registers_tb.sv
